// File: rtl/core/tcdq_pkg.sv
// ----------------------------------------------------------------------------
// tcdq_pkg
// Shared types and constants for the timestamped command delay queue.
// ----------------------------------------------------------------------------
package tcdq_pkg;

    typedef enum logic [0:0] {
        CMD_SET = 1'b0,
        CMD_GET = 1'b1
    } t_cmd;

    // One ring entry; vx sits in the lowest bits.
    typedef struct packed {
        logic               chip;
        logic [7:0]         dribble;
        logic [7:0]         kick;
        logic signed [23:0] va;
        logic signed [23:0] vy;
        logic signed [23:0] vx;
    } t_entry;

    localparam int unsigned ENTRY_W  = $bits(t_entry);
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned LAT_W    = 16;
    localparam int unsigned S_DATA_W = 128;
    localparam int unsigned M_DATA_W = 96;

    localparam logic [TIME_W-1:0] DUE_MAX = 32'h7fff_ffff;

endpackage

// File: rtl/core/timestamped_command_delay_queue.sv
// ----------------------------------------------------------------------------
// timestamped_command_delay_queue
// Ring of motion commands released by due time (stamp plus latency).
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata: command fields, tuser: set/get
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata: executing entry
//   cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_data: latency in frames
//
// One word per cycle while the result register is not stalled. A get result passes
// through the registered ring RAM read, then the result register loads.
// Ring RAM reads forward the write of the previous word.
// A get waiting on a full, stalled result register holds the input side.
// Reset sets exec ptr 0, write ptr 1, clears valid bits, latency; no clearing pass.
// ----------------------------------------------------------------------------
module timestamped_command_delay_queue
    import tcdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // [31:0] time_now, [55:32] in_vx, [79:56] in_vy, [103:80] in_va,
    // [111:104] in_kick, [119:112] in_dribble, [120] in_chip
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // [0] command
    input  logic                s_axis_tuser,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [23:0] out_vx, [47:24] out_vy, [71:48] out_va, [79:72] out_kick,
    // [87:80] out_dribble, [88] out_chip
    output logic [M_DATA_W-1:0] m_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [LAT_W-1:0]    i_cfg_data
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    logic [LAT_W-1:0]       r_lat;
    logic [IDX_W-1:0]       r_exec, n_exec;
    logic [IDX_W-1:0]       r_wr, n_wr;
    logic [CNT_W-1:0]       r_pend, n_pend;
    logic [QUEUE_DEPTH-1:0] r_vld;

    logic                   r_s1_valid;
    t_cmd                   r_s1_cmd;
    logic [TIME_W-1:0]      r_s1_now;
    logic [TIME_W-1:0]      r_s1_due;
    t_entry                 r_s1_ent;
    logic                   r_s1_byp_due, r_s1_byp_ent;
    logic                   r_s1_vld_due, r_s1_vld_ent;

    logic [TIME_W-1:0]      r_last_due;
    t_entry                 r_last_ent;

    logic                   r_out_valid;
    t_entry                 r_out_ent;

    logic [TIME_W-1:0]      due_rdata;
    logic [ENTRY_W-1:0]     ent_rdata;
    logic [TIME_W-1:0]      s1_due_q;
    t_entry                 s1_ent_q;

    logic                   out_free, s1_fire, accept;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [IDX_W-1:0]       due_raddr, ent_raddr;

    t_cmd                   in_cmd;
    logic [TIME_W-1:0]      in_now;
    t_entry                 in_ent;
    logic [TIME_W:0]        in_sum;
    logic [TIME_W-1:0]      in_due;

    assign in_cmd = t_cmd'(s_axis_tuser);
    assign in_now = s_axis_tdata[TIME_W-1:0];
    assign in_ent = t_entry'(s_axis_tdata[TIME_W+ENTRY_W-1:TIME_W]);
    assign in_sum = {in_now[TIME_W-1], in_now} + {{(TIME_W+1-LAT_W){1'b0}}, r_lat};
    assign in_due = (in_sum[TIME_W:TIME_W-1] == 2'b01) ? DUE_MAX : in_sum[TIME_W-1:0];

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_fire       = r_s1_valid && ((r_s1_cmd == CMD_SET) || out_free);
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign s1_due_q = r_s1_byp_due ? r_last_due :
                      (r_s1_vld_due ? due_rdata : '0);
    assign s1_ent_q = r_s1_byp_ent ? r_last_ent :
                      (r_s1_vld_ent ? t_entry'(ent_rdata) : t_entry'('0));

    always_comb begin
        n_exec  = r_exec;
        n_wr    = r_wr;
        n_pend  = r_pend;
        wr_en   = 1'b0;
        wr_addr = r_wr;
        if (s1_fire) begin
            case (r_s1_cmd)
                CMD_SET: begin
                    if (r_s1_due == s1_due_q) begin
                        wr_en   = 1'b1;
                        wr_addr = idx_dec(r_wr);
                    end else if (($signed(r_s1_due) < $signed(s1_due_q))
                                 || (r_wr == r_exec)) begin
                        wr_en = 1'b0;
                    end else begin
                        wr_en  = 1'b1;
                        n_wr   = idx_inc(r_wr);
                        n_pend = r_pend + 1'b1;
                    end
                end
                CMD_GET: begin
                    if ((r_pend != '0) && ($signed(s1_due_q) <= $signed(r_s1_now))) begin
                        n_exec = idx_inc(r_exec);
                        n_pend = r_pend - 1'b1;
                    end
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
        due_raddr = (in_cmd == CMD_SET) ? idx_dec(n_wr) : idx_inc(n_exec);
        ent_raddr = n_exec;
    end

    tcdq_ram #(
        .WIDTH (TIME_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_due_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (r_s1_due),
        .i_re    (accept),
        .i_raddr (due_raddr),
        .o_rdata (due_rdata)
    );

    tcdq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (r_s1_ent),
        .i_re    (accept),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat       <= '0;
            r_exec      <= '0;
            r_wr        <= IDX_W'(1);
            r_pend      <= '0;
            r_vld       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_lat <= i_cfg_data;
            end
            r_exec <= n_exec;
            r_wr   <= n_wr;
            r_pend <= n_pend;
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire && (r_s1_cmd == CMD_GET)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd     <= in_cmd;
            r_s1_now     <= in_now;
            r_s1_due     <= in_due;
            r_s1_ent     <= in_ent;
            r_s1_byp_due <= wr_en && (wr_addr == due_raddr);
            r_s1_byp_ent <= wr_en && (wr_addr == ent_raddr);
            r_s1_vld_due <= r_vld[due_raddr];
            r_s1_vld_ent <= r_vld[ent_raddr];
        end
        if (wr_en) begin
            r_last_due <= r_s1_due;
            r_last_ent <= r_s1_ent;
        end
        if (s1_fire && (r_s1_cmd == CMD_GET)) begin
            r_out_ent <= s1_ent_q;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_DATA_W-ENTRY_W){1'b0}}, r_out_ent};

endmodule

// File: rtl/core/tcdq_ram.sv
// ----------------------------------------------------------------------------
// tcdq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/tcdq_checker.sv
// ----------------------------------------------------------------------------
// tcdq_checker
// Port-level checks for the timestamped command delay queue.
// ----------------------------------------------------------------------------
module tcdq_checker
    import tcdq_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                s_axis_tuser,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // input side only backs off behind a stalled result
    a_bp_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input not ready without output stall");

    // a fresh result comes from a get word taken earlier at the input
    a_rose_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |->
            $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_GET), 2))
        else $error("result without a get word");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind timestamped_command_delay_queue tcdq_checker u_tcdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
